### hdl/tcm_pkg.sv
`default_nettype none

package tcm_pkg;

    // Screen geometry in pixels
    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;

    // Raw conversions per axis; a power of two so the average is a shift
    localparam int SAMPLES      = 4;
    localparam int SAMPLE_SHIFT = $clog2(SAMPLES);

    localparam int RAW_W = 12;
    localparam int SUM_W = RAW_W + SAMPLE_SHIFT;
    localparam int SX_W  = $clog2(SCREEN_WIDTH);
    localparam int SY_W  = $clog2(SCREEN_HEIGHT);

    // Quotient holds 0..scale, scale is the larger screen dimension at most
    localparam int SCALE_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
    localparam int Q_W       = $clog2(SCALE_MAX + 1);
    // Dividend is offset times scale
    localparam int N_W       = RAW_W + Q_W;

    // Lane pipeline: window stage, scale stage, one stage per quotient bit
    localparam int LANE_LAT = Q_W + 2;

    // Configuration register file
    localparam int CFG_W   = RAW_W;
    localparam int CFG_IDX = 3;

    typedef enum logic [CFG_IDX-1:0] {
        REG_RAW_X_LOW   = 3'd0,
        REG_RAW_X_HIGH  = 3'd1,
        REG_RAW_Y_LOW   = 3'd2,
        REG_RAW_Y_HIGH  = 3'd3,
        REG_ORIENTATION = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        ORIENT_PORTRAIT      = 2'd0,
        ORIENT_LANDSCAPE     = 2'd1,
        ORIENT_PORTRAIT_FLIP = 2'd2,
        ORIENT_LANDSCAPE_ALT = 2'd3
    } t_orient;

    localparam logic [RAW_W-1:0] RST_RAW_X_LOW  = RAW_W'(200);
    localparam logic [RAW_W-1:0] RST_RAW_X_HIGH = RAW_W'(3700);
    localparam logic [RAW_W-1:0] RST_RAW_Y_LOW  = RAW_W'(240);
    localparam logic [RAW_W-1:0] RST_RAW_Y_HIGH = RAW_W'(3800);

    typedef logic [RAW_W-1:0] t_raw;

    // Per-item control that travels beside the lanes
    typedef struct packed {
        logic valid;
        logic pen;
    } t_ctl;

endpackage

`default_nettype wire

### hdl/tcm_divider.sv
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage, MSB first.
// Requires num < den << Q_W, which holds since num <= den * scale.
module tcm_divider
    import tcm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic [N_W-1:0]   i_num,
    input  wire logic [RAW_W-1:0] i_den,
    output logic      [Q_W-1:0]   o_quot
);

    logic [N_W-1:0]   r_rem  [Q_W-1];
    logic [RAW_W-1:0] r_den  [Q_W-1];
    logic [Q_W-1:0]   r_quot [Q_W];

    for (genvar j = 0; j < Q_W; j++) begin : g_step
        localparam int B = Q_W - 1 - j;

        logic [N_W-1:0]   w_rem_in;
        logic [N_W-1:0]   w_sub;
        logic [RAW_W-1:0] w_den_in;
        logic [Q_W-1:0]   w_q_in;
        logic             w_ge;

        if (j == 0) begin : g_first
            assign w_rem_in = i_num;
            assign w_den_in = i_den;
            assign w_q_in   = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[j-1];
            assign w_den_in = r_den[j-1];
            assign w_q_in   = r_quot[j-1];
        end

        // Trial subtract of the shifted divisor
        assign w_sub = N_W'(w_den_in) << B;
        assign w_ge  = (w_rem_in >= w_sub);

        always_ff @(posedge i_clk) begin
            r_quot[j] <= w_q_in | (w_ge ? (Q_W'(1) << B) : '0);
        end

        // Remainder and divisor only feed later stages
        if (j < Q_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[j] <= w_ge ? (w_rem_in - w_sub) : w_rem_in;
                r_den[j] <= w_den_in;
            end
        end
    end

    assign o_quot = r_quot[Q_W-1];

endmodule

`default_nettype wire

### hdl/tcm_lane.sv
`default_nettype none

// One axis: average, window clamp, scale and divide.
// Output is floor(offset * scale / span), 0..scale.
module tcm_lane
    import tcm_pkg::*;
(
    input  wire logic           i_clk,
    input  wire t_raw           i_samples [SAMPLES],
    input  wire t_raw           i_low,
    input  wire t_raw           i_high,
    input  wire logic [Q_W-1:0] i_scale,
    output logic      [Q_W-1:0] o_quot
);

    logic [SUM_W-1:0] w_sum;
    t_raw             w_avg;
    t_raw             w_clamped;
    logic             w_below;

    logic             r_ok;
    logic             r_full;
    t_raw             r_diff;
    t_raw             r_span;

    logic [N_W-1:0]   r_num;
    t_raw             r_den;

    // Sum of the conversions, averaged by shift
    always_comb begin
        w_sum = '0;
        for (int i = 0; i < SAMPLES; i++) begin
            w_sum = w_sum + SUM_W'(i_samples[i]);
        end
    end

    assign w_avg   = w_sum[SUM_W-1:SAMPLE_SHIFT];
    assign w_below = (w_avg < i_low);

    // Clamp: below low wins over above high for an inverted window
    assign w_clamped = w_below ? i_low : ((w_avg > i_high) ? i_high : w_avg);

    // Window stage
    always_ff @(posedge i_clk) begin
        r_ok   <= (i_low < i_high);
        // Inverted window with the average at or above low maps to full scale
        r_full <= (i_low > i_high) && !w_below;
        r_diff <= w_clamped - i_low;
        r_span <= i_high - i_low;
    end

    // Scale stage; degenerate windows become num 0 or scale over 1
    always_ff @(posedge i_clk) begin
        if (r_ok) begin
            r_num <= N_W'(r_diff) * N_W'(i_scale);
            r_den <= r_span;
        end else begin
            r_num <= r_full ? N_W'(i_scale) : '0;
            r_den <= RAW_W'(1);
        end
    end

    tcm_divider u_div (
        .i_clk  (i_clk),
        .i_num  (r_num),
        .i_den  (r_den),
        .o_quot (o_quot)
    );

endmodule

`default_nettype wire

### hdl/tcm_merge.sv
`default_nettype none

// Combines the two lane quotients by orientation and clamps to the screen.
module tcm_merge
    import tcm_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_ctl            i_ctl,
    input  wire t_orient         i_orient,
    input  wire logic [Q_W-1:0]  i_quot_x,
    input  wire logic [Q_W-1:0]  i_quot_y,
    output logic                 o_done,
    output logic                 o_touched,
    output logic      [SX_W-1:0] o_screen_x,
    output logic      [SY_W-1:0] o_screen_y
);

    logic [Q_W-1:0]  w_map_x;
    logic [Q_W-1:0]  w_map_y;
    logic [Q_W-1:0]  w_pre_x;
    logic [Q_W-1:0]  w_pre_y;
    logic [SX_W-1:0] w_scr_x;
    logic [SY_W-1:0] w_scr_y;

    logic            r_done;
    logic            r_touched;
    logic [SX_W-1:0] r_screen_x;
    logic [SY_W-1:0] r_screen_y;

    // Portrait maps upward from zero, all other modes downward from scale
    assign w_map_x = (i_orient == ORIENT_PORTRAIT) ? i_quot_x
                                                   : Q_W'(SCREEN_HEIGHT) - i_quot_x;
    assign w_map_y = (i_orient == ORIENT_PORTRAIT) ? i_quot_y
                                                   : Q_W'(SCREEN_WIDTH) - i_quot_y;

    // Landscape swaps the axes
    always_comb begin
        unique case (i_orient)
            ORIENT_LANDSCAPE, ORIENT_LANDSCAPE_ALT: begin
                w_pre_x = w_map_y;
                w_pre_y = w_map_x;
            end
            default: begin
                w_pre_x = w_map_x;
                w_pre_y = w_map_y;
            end
        endcase
    end

    // Clamp to the last pixel
    assign w_scr_x = (w_pre_x > Q_W'(SCREEN_WIDTH - 1)) ? SX_W'(SCREEN_WIDTH - 1)
                                                        : SX_W'(w_pre_x);
    assign w_scr_y = (w_pre_y > Q_W'(SCREEN_HEIGHT - 1)) ? SY_W'(SCREEN_HEIGHT - 1)
                                                         : SY_W'(w_pre_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_ctl.valid;
        end
    end

    // Result payload; pen up reports zero coordinates
    always_ff @(posedge i_clk) begin
        r_touched  <= i_ctl.pen;
        r_screen_x <= i_ctl.pen ? w_scr_x : '0;
        r_screen_y <= i_ctl.pen ? w_scr_y : '0;
    end

    assign o_done     = r_done;
    assign o_touched  = r_touched;
    assign o_screen_x = r_screen_x;
    assign o_screen_y = r_screen_y;

endmodule

`default_nettype wire

### hdl/touch_average_calibrate_map_top.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// command   in         start, busy          i_pen_down, i_x_sample_0..3, i_y_sample_0..3
// result    out        o_done (one cycle)   o_touched, o_screen_x, o_screen_y
// config    in         i_cfg_we             i_cfg_index, i_cfg_data
//
// One transfer is accepted every cycle; busy is high only during reset.
// Each result is registered through the window stage, the scale stage,
// 9 divider stages (one quotient bit each) and the output stage.
// Synchronous active-low reset clears control state and loads the register
// defaults. The receiver cannot stall; results are never held.
module touch_average_calibrate_map_top
    import tcm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_pen_down,
    input  wire logic [RAW_W-1:0]   i_x_sample_0,
    input  wire logic [RAW_W-1:0]   i_x_sample_1,
    input  wire logic [RAW_W-1:0]   i_x_sample_2,
    input  wire logic [RAW_W-1:0]   i_x_sample_3,
    input  wire logic [RAW_W-1:0]   i_y_sample_0,
    input  wire logic [RAW_W-1:0]   i_y_sample_1,
    input  wire logic [RAW_W-1:0]   i_y_sample_2,
    input  wire logic [RAW_W-1:0]   i_y_sample_3,
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_IDX-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]   i_cfg_data,
    output logic                    o_done,
    output logic                    o_touched,
    output logic      [SX_W-1:0]    o_screen_x,
    output logic      [SY_W-1:0]    o_screen_y
);

    t_raw     r_x_low;
    t_raw     r_x_high;
    t_raw     r_y_low;
    t_raw     r_y_high;
    t_orient  r_orient;

    t_ctl     r_ctl [LANE_LAT];
    logic     w_accept;

    t_raw     w_x_samples [SAMPLES];
    t_raw     w_y_samples [SAMPLES];
    logic [Q_W-1:0] w_quot_x;
    logic [Q_W-1:0] w_quot_y;

    assign busy     = !i_rst_n;
    assign w_accept = start && !busy;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_low  <= RST_RAW_X_LOW;
            r_x_high <= RST_RAW_X_HIGH;
            r_y_low  <= RST_RAW_Y_LOW;
            r_y_high <= RST_RAW_Y_HIGH;
            r_orient <= ORIENT_LANDSCAPE;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_RAW_X_LOW:   r_x_low  <= i_cfg_data[RAW_W-1:0];
                REG_RAW_X_HIGH:  r_x_high <= i_cfg_data[RAW_W-1:0];
                REG_RAW_Y_LOW:   r_y_low  <= i_cfg_data[RAW_W-1:0];
                REG_RAW_Y_HIGH:  r_y_high <= i_cfg_data[RAW_W-1:0];
                REG_ORIENTATION: r_orient <= t_orient'(i_cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    // Control delay line matching the lane latency
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LANE_LAT; i++) begin
                r_ctl[i] <= '0;
            end
        end else begin
            r_ctl[0] <= '{valid: w_accept, pen: i_pen_down};
            for (int i = 1; i < LANE_LAT; i++) begin
                r_ctl[i] <= r_ctl[i-1];
            end
        end
    end

    assign w_x_samples[0] = i_x_sample_0;
    assign w_x_samples[1] = i_x_sample_1;
    assign w_x_samples[2] = i_x_sample_2;
    assign w_x_samples[3] = i_x_sample_3;
    assign w_y_samples[0] = i_y_sample_0;
    assign w_y_samples[1] = i_y_sample_1;
    assign w_y_samples[2] = i_y_sample_2;
    assign w_y_samples[3] = i_y_sample_3;

    // Raw X always scales to the screen height, raw Y to the width
    tcm_lane u_lane_x (
        .i_clk     (i_clk),
        .i_samples (w_x_samples),
        .i_low     (r_x_low),
        .i_high    (r_x_high),
        .i_scale   (Q_W'(SCREEN_HEIGHT)),
        .o_quot    (w_quot_x)
    );

    tcm_lane u_lane_y (
        .i_clk     (i_clk),
        .i_samples (w_y_samples),
        .i_low     (r_y_low),
        .i_high    (r_y_high),
        .i_scale   (Q_W'(SCREEN_WIDTH)),
        .o_quot    (w_quot_y)
    );

    tcm_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (r_ctl[LANE_LAT-1]),
        .i_orient   (r_orient),
        .i_quot_x   (w_quot_x),
        .i_quot_y   (w_quot_y),
        .o_done     (o_done),
        .o_touched  (o_touched),
        .o_screen_x (o_screen_x),
        .o_screen_y (o_screen_y)
    );

`ifndef NO_ASSERTIONS
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_ctl[0].valid)
        else $error("accepted command missing from control line");

    a_leave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl[LANE_LAT-1].valid |=> o_done)
        else $error("lane result not reported");

    a_pen_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_touched) |-> (o_screen_x == '0 && o_screen_y == '0))
        else $error("pen-up result has nonzero coordinates");

    a_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_screen_x < SX_W'(SCREEN_WIDTH) && o_screen_y < SY_W'(SCREEN_HEIGHT)))
        else $error("coordinate outside the screen");
`endif

endmodule

`default_nettype wire
